// ===== src/assert_macros.svh =====
// Shared concurrent assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define AMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that two conditions are never true in the same cycle.
`define AMT_ASSERT_EXCL(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !((a) && (b))) else $error(msg);

`endif

// ===== src/amt_pkg.sv =====
package amt_pkg;

  localparam int unsigned FIELD_W       = 32;
  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned ACC_W         = 51;
  localparam int unsigned N_ELEM        = 16;

  typedef enum logic [3:0] {
    OP_WR_MAIN   = 4'd0,
    OP_WR_OPND   = 4'd1,
    OP_RD_MAIN   = 4'd2,
    OP_IDENTITY  = 4'd3,
    OP_TRANSFORM = 4'd4,
    OP_TRANSLATE = 4'd5,
    OP_SCALE     = 4'd6,
    OP_APPEND    = 4'd7,
    OP_TRANSPOSE = 4'd8
  } op_e;

  typedef struct packed {
    logic [3:0]         opcode;
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
  } out_t;

  typedef struct packed {
    logic       valid;
    logic       rd_opnd;
    logic [3:0] rd_addr;
    logic       pass;
    logic       load;
    logic       bsel;
    logic [1:0] bidx;
    logic       first;
    logic       last;
    logic       wr;
    logic [3:0] wr_addr;
    logic       out_en;
    logic [1:0] out_idx;
  } step_t;

  // Off-diagonal elements, each directly followed by its mirror element.
  function automatic logic [3:0] tr_addr(input logic [3:0] s);
    logic [3:0] a;
    case (s)
      4'd0:    a = 4'd1;
      4'd1:    a = 4'd4;
      4'd2:    a = 4'd2;
      4'd3:    a = 4'd8;
      4'd4:    a = 4'd3;
      4'd5:    a = 4'd12;
      4'd6:    a = 4'd6;
      4'd7:    a = 4'd9;
      4'd8:    a = 4'd7;
      4'd9:    a = 4'd13;
      4'd10:   a = 4'd11;
      4'd11:   a = 4'd14;
      default: a = 4'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== src/amt_ram.sv =====
module amt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/affine_matrix_transform_unit_core.sv =====
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   in_item_i  (in_t)
// out       output     out_valid_o / out_stall_i out_item_o (out_t)
//
// A write, identity or unused opcode returns its result without running any elements.
// An opcode that runs elements (read, transform, translate, scale, transpose, append) steps
// through them one element per cycle, then drains the pipeline before its result appears.
// The next item can be accepted in the same cycle that the result appears.
// Reset loads both matrices with identity through per-element valid bits.
// An item is taken while a result waits; its work starts once the output is free.
module affine_matrix_transform_unit_core
  import amt_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_item_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_item_o
);

  `include "assert_macros.svh"

  localparam int unsigned VW = (WORD_BITS > FIELD_W) ? FIELD_W : WORD_BITS;
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((64'sd1 <<< (VW - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] ONE_ACC = ACC_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [VW-1:0] IDENT_VAL =
    (ONE_ACC > SAT_MAX) ? VW'(SAT_MAX) : VW'(ONE_ACC);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WAIT  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_e;

  function automatic logic signed [VW-1:0] sat_vw(input logic signed [ACC_W-1:0] v);
    logic signed [VW-1:0] r;
    if (v > SAT_MAX) begin
      r = VW'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      r = VW'(SAT_MIN);
    end else begin
      r = VW'(v);
    end
    return r;
  endfunction

  state_e state_q, state_d;
  in_t    item_q;
  op_e    op;
  logic [6:0] step_q, step_d;
  logic [N_ELEM-1:0] main_vld_q, opnd_vld_q;
  logic signed [FIELD_W-1:0] buf_q [4];
  logic signed [FIELD_W-1:0] res_q [4];
  logic signed [FIELD_W-1:0] vec [4];
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  step_t st, ctl1_q, ctl2_q;
  logic  step_last;
  logic  rv1_q;
  logic signed [ACC_W-1:0] prod_q, prod_d, acc_q, sum;
  logic signed [VW-1:0] sum_sat, elem_sat, a_vw;
  logic signed [FIELD_W-1:0] a32, b32;
  logic signed [2*FIELD_W-1:0] mul;
  logic [VW-1:0] main_rdata, opnd_rdata;

  logic out_free, start, start_run, start_wr_main, start_wr_opnd, start_ident, s2_wr;
  logic pipe_empty;
  logic main_we;
  logic [3:0] main_waddr;
  logic [VW-1:0] main_wdata;

  assign op  = op_e'(item_q.opcode);
  assign vec[0] = item_q.in_x;
  assign vec[1] = item_q.in_y;
  assign vec[2] = item_q.in_z;
  assign vec[3] = item_q.in_w;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign start      = (state_q == ST_WAIT) && out_free;
  assign start_run  = start && (op == OP_RD_MAIN || op == OP_TRANSFORM ||
                      op == OP_TRANSLATE || op == OP_SCALE || op == OP_APPEND ||
                      op == OP_TRANSPOSE);
  assign start_wr_main = start && (op == OP_WR_MAIN);
  assign start_wr_opnd = start && (op == OP_WR_OPND);
  assign start_ident   = start && (op == OP_IDENTITY);
  assign pipe_empty    = !ctl1_q.valid && !ctl2_q.valid;

  always_comb begin
    logic [1:0] r;
    logic [1:0] c;
    logic [1:0] ar;
    logic [4:0] sub;
    logic [3:0] m;
    logic [3:0] ta;
    st = '0;
    step_last = 1'b1;
    r   = step_q[3:2];
    c   = step_q[1:0];
    ar  = step_q[6:5];
    sub = step_q[4:0];
    m   = 4'(sub - 5'd4);
    ta  = tr_addr(step_q[3:0]);
    case (op)
      OP_RD_MAIN: begin
        st.rd_addr = item_q.elem_index;
        st.pass    = 1'b1;
        st.first   = 1'b1;
        st.last    = 1'b1;
        st.out_en  = 1'b1;
      end
      OP_TRANSFORM, OP_TRANSLATE: begin
        st.rd_addr = {c, r};
        st.bidx    = c;
        st.first   = (c == 2'd0);
        st.last    = (c == 2'd3);
        if (op == OP_TRANSLATE) begin
          st.pass    = (c == 2'd3);
          st.wr      = (c == 2'd3);
          st.wr_addr = {2'd3, r};
        end else begin
          st.out_en  = (c == 2'd3);
          st.out_idx = r;
        end
        step_last = (step_q[3:0] == 4'd15);
      end
      OP_SCALE: begin
        st.rd_addr = step_q[3:0];
        st.bidx    = step_q[3:2];
        st.first   = 1'b1;
        st.last    = 1'b1;
        st.wr      = 1'b1;
        st.wr_addr = step_q[3:0];
        step_last  = (step_q[3:0] == 4'd11);
      end
      OP_APPEND: begin
        if (sub < 5'd4) begin
          st.load    = 1'b1;
          st.rd_addr = {sub[1:0], ar};
          st.bidx    = sub[1:0];
        end else begin
          st.rd_opnd = 1'b1;
          st.rd_addr = m;
          st.bsel    = 1'b1;
          st.bidx    = m[1:0];
          st.first   = (m[1:0] == 2'd0);
          st.last    = (m[1:0] == 2'd3);
          st.wr      = (m[1:0] == 2'd3);
          st.wr_addr = {m[3:2], ar};
        end
        step_last = (ar == 2'd3) && (sub == 5'd19);
      end
      OP_TRANSPOSE: begin
        st.rd_addr = ta;
        st.pass    = 1'b1;
        st.first   = 1'b1;
        st.last    = 1'b1;
        st.wr      = 1'b1;
        st.wr_addr = {ta[1:0], ta[3:2]};
        step_last  = (step_q[3:0] == 4'd11);
      end
      default: begin
        step_last = 1'b1;
      end
    endcase
    st.valid = (state_q == ST_RUN);
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (start_run) begin
          state_d = ST_RUN;
          step_d  = '0;
        end else if (start) begin
          state_d = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (step_last) begin
          state_d = ST_DRAIN;
        end else if (op == OP_APPEND && step_q[4:0] == 5'd19) begin
          step_d = {step_q[6:5] + 2'd1, 5'd0};
        end else begin
          step_d = step_q + 7'd1;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (start && !start_run) begin
      out_valid_d = 1'b1;
      out_d       = '0;
    end else if (state_q == ST_DRAIN && pipe_empty) begin
      out_valid_d = 1'b1;
      out_d       = '{res_q[0], res_q[1], res_q[2], res_q[3]};
    end
  end

  // Read stage: the memory word arrives, the multiplier forms the product.
  always_comb begin
    a_vw = ctl1_q.rd_opnd ? signed'(opnd_rdata) : signed'(main_rdata);
    if (!rv1_q) begin
      a_vw = (ctl1_q.rd_addr[3:2] == ctl1_q.rd_addr[1:0]) ? IDENT_VAL : '0;
    end
    a32 = FIELD_W'(a_vw);
    b32 = ctl1_q.bsel ? buf_q[ctl1_q.bidx] : vec[ctl1_q.bidx];
    mul = a32 * b32;
    prod_d = ctl1_q.pass ? ACC_W'(a32) : ACC_W'(signed'(mul[2*FIELD_W-1:FRAC_BITS]));
  end

  assign sum      = (ctl2_q.first ? '0 : acc_q) + prod_q;
  assign sum_sat  = sat_vw(sum);
  assign elem_sat = sat_vw(ACC_W'(item_q.elem_value));
  assign s2_wr    = ctl2_q.valid && ctl2_q.last && ctl2_q.wr;

  assign main_we    = start_wr_main || s2_wr;
  assign main_waddr = s2_wr ? ctl2_q.wr_addr : item_q.elem_index;
  assign main_wdata = s2_wr ? sum_sat : elem_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      main_vld_q  <= '0;
      opnd_vld_q  <= '0;
      out_valid_q <= 1'b0;
      ctl1_q      <= '0;
      ctl2_q      <= '0;
      rv1_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      ctl1_q      <= st;
      ctl2_q      <= ctl1_q;
      rv1_q       <= st.rd_opnd ? opnd_vld_q[st.rd_addr] : main_vld_q[st.rd_addr];
      if (start_ident) begin
        main_vld_q <= '0;
      end else if (main_we) begin
        main_vld_q[main_waddr] <= 1'b1;
      end
      if (start_wr_opnd) begin
        opnd_vld_q[item_q.elem_index] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_item_i;
    end
    out_q  <= out_d;
    prod_q <= prod_d;
    if (ctl1_q.valid && ctl1_q.load) begin
      buf_q[ctl1_q.bidx] <= a32;
    end
    if (ctl2_q.valid && !ctl2_q.load) begin
      acc_q <= sum;
    end
    if (start_run) begin
      res_q <= '{default: '0};
    end else if (ctl2_q.valid && ctl2_q.last && ctl2_q.out_en) begin
      res_q[ctl2_q.out_idx] <= FIELD_W'(sum_sat);
    end
  end

  amt_ram #(
    .WIDTH(VW),
    .DEPTH(N_ELEM)
  ) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (main_we),
    .waddr_i (main_waddr),
    .wdata_i (main_wdata),
    .raddr_i (st.rd_addr),
    .rdata_o (main_rdata)
  );

  amt_ram #(
    .WIDTH(VW),
    .DEPTH(N_ELEM)
  ) u_opnd_ram (
    .clk_i   (clk_i),
    .we_i    (start_wr_opnd),
    .waddr_i (item_q.elem_index),
    .wdata_i (elem_sat),
    .raddr_i (st.rd_addr),
    .rdata_o (opnd_rdata)
  );

  `AMT_ASSERT(a_accept_wait, (in_valid_i && !in_stall_o) |=> (state_q == ST_WAIT), "item not held")
  `AMT_ASSERT_EXCL(a_wr_excl, start_wr_main, s2_wr, "two main matrix writes in one cycle")
  `AMT_ASSERT(a_pipe_state, ctl1_q.valid |-> (state_q == ST_RUN || state_q == ST_DRAIN), "busy")
  `AMT_ASSERT(a_drain_out, (state_q == ST_DRAIN && pipe_empty) |=> out_valid_o, "no result")

endmodule
